// ===== rtl/bmp_pixel_array_decoder_macros.svh =====
// Assertion macros for the BMP pixel array decoder checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BMP_PIXEL_ARRAY_DECODER_MACROS_SVH
`define BMP_PIXEL_ARRAY_DECODER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define BPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpd check failed");

// Next-cycle implication, disabled while in reset
`define BPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpd check failed");

`endif

// ===== rtl/bpd_pkg.sv =====
// Shared types and codes for the BMP pixel array decoder.
// No dependencies; used by every RTL file of the block except bpd_ram and the macros header.
`timescale 1ns / 1ps

package bpd_pkg;

  // Fixed widths of the counters and geometry values
  localparam int DIM_W   = 13;  // width/height registers
  localparam int POS_W   = 15;  // byte position within a file row
  localparam int Q_DEPTH = 4;   // front-to-back queue entries
  localparam int Q_AW    = 2;

  // Pixel formats
  localparam logic [1:0] FMT_PAL4  = 2'd0;
  localparam logic [1:0] FMT_PAL8  = 2'd1;
  localparam logic [1:0] FMT_BGR24 = 2'd2;

  // Request kinds
  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Component phases of a 24-bit triple
  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_of_image;
    logic        last_of_item;
  } out_item_t;

  // Geometry derived from the configuration registers
  typedef struct packed {
    logic [1:0]       fmt;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [POS_W-1:0] data_bytes;
    logic [POS_W-1:0] stride;
  } geom_t;

  // Operations handed from front to back
  typedef enum logic [1:0] {
    OP_PAL_WR,
    OP_LOOKUP,
    OP_DIRECT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        two_px;
    logic [7:0]  idx0;
    logic [7:0]  idx1;
    logic [23:0] rgb;
    logic [11:0] column;
    logic [11:0] row;
    logic        last0;
    logic        last1;
  } work_t;

endpackage

// ===== rtl/bmp_pixel_array_decoder.sv =====
// BMP pixel array decoder. Takes one request per cycle while in_stall is low: a
// palette entry write or one byte of the pixel array in file order, and yields
// RGB pixels with their column and top-down row. A byte gives zero, one or (4-bit
// format) two pixels. The configuration registers accept a new request every
// cycle and the front end does so while the queue is not full; the back end emits
// one pixel per cycle while out_stall is low, so 4-bit bytes that each carry two
// pixels are held back by the single output port. A byte's first pixel passes the
// queue, palette read and output register. The palette needs no clearing after
// reset; an entry must be written before it is used. Writing a register restarts
// the image; write registers only while no request is in flight.
`timescale 1ns / 1ps

module bmp_pixel_array_decoder #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bpd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bpd_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bpd_pkg::*;

  localparam int MAXW_I = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
  localparam int MAXH_I = (MAX_HEIGHT > 8191) ? 8191 : MAX_HEIGHT;
  localparam logic [DIM_W-1:0] MAXW_C = DIM_W'(MAXW_I);
  localparam logic [DIM_W-1:0] MAXH_C = DIM_W'(MAXH_I);

  logic [1:0]       fmt_r, fmt_nxt;
  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  geom_t            geom_r, geom_nxt;

  logic             wr_en, restart;
  logic [1:0]       reg_idx;
  logic [DIM_W-1:0] w_cl, h_cl;

  logic  q_push, q_full, q_pop, q_not_empty;
  work_t q_wdata, q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign restart = wr_en &&
                   (reg_idx == REG_FORMAT || reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT);

  // Register writes
  always_comb begin
    fmt_nxt    = fmt_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FORMAT: fmt_nxt    = pwdata[1:0];
        REG_WIDTH:  width_nxt  = pwdata[DIM_W-1:0];
        REG_HEIGHT: height_nxt = pwdata[DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_FORMAT: prdata = {30'd0, fmt_r};
      REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, width_r};
      REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_r};
      default:    prdata = '0;
    endcase
  end

  // Clamp dimensions and derive row geometry from the new register values
  always_comb begin
    w_cl = (width_nxt == '0) ? DIM_W'(1) : ((width_nxt > MAXW_C) ? MAXW_C : width_nxt);
    h_cl = (height_nxt == '0) ? DIM_W'(1) : ((height_nxt > MAXH_C) ? MAXH_C : height_nxt);
    geom_nxt.fmt = fmt_nxt;
    geom_nxt.w   = w_cl;
    geom_nxt.h   = h_cl;
    if (fmt_nxt == FMT_PAL4) begin
      geom_nxt.data_bytes = POS_W'((POS_W'(w_cl) + POS_W'(1)) >> 1);
    end else if (fmt_nxt == FMT_PAL8) begin
      geom_nxt.data_bytes = POS_W'(w_cl);
    end else begin
      geom_nxt.data_bytes = POS_W'({w_cl, 1'b0}) + POS_W'(w_cl);
    end
    geom_nxt.stride = (geom_nxt.data_bytes + POS_W'(3)) & ~POS_W'(3);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r             <= FMT_BGR24;
      width_r           <= DIM_W'(1);
      height_r          <= DIM_W'(1);
      geom_r.fmt        <= FMT_BGR24;
      geom_r.w          <= DIM_W'(1);
      geom_r.h          <= DIM_W'(1);
      geom_r.data_bytes <= POS_W'(3);
      geom_r.stride     <= POS_W'(4);
    end else begin
      fmt_r    <= fmt_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      geom_r   <= geom_nxt;
    end
  end

  bpd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .geom    (geom_r),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  bpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  bpd_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/bpd_ram.sv =====
// Generic memory: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bpd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ===== rtl/bpd_front.sv =====
// Front end: accepts requests, tracks row/column/byte position, classifies bytes.
// Depends on bpd_pkg; feeds bpd_queue.
`timescale 1ns / 1ps

module bpd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  bpd_pkg::geom_t    geom,
  input  logic              in_valid,
  output logic              in_stall,
  input  bpd_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output bpd_pkg::work_t    q_wdata
);
  import bpd_pkg::*;

  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] frow_r, frow_nxt;
  logic [POS_W-1:0] rbp_r, rbp_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [15:0]      held_r, held_nxt;

  logic             accept;
  logic [POS_W-1:0] rbp_inc;
  logic             in_row;
  logic [DIM_W-1:0] col_p1, col_p2, frow_p1, row_out;
  logic             last_row;
  logic [7:0]       b;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_data.data_byte;

  // Position arithmetic
  assign rbp_inc  = rbp_r + POS_W'(1);
  assign in_row   = rbp_r < geom.data_bytes;
  assign col_p1   = col_r + DIM_W'(1);
  assign col_p2   = col_r + DIM_W'(2);
  assign frow_p1  = frow_r + DIM_W'(1);
  assign last_row = frow_p1 == geom.h;
  assign row_out  = geom.h - DIM_W'(1) - frow_r;

  // Classify the request and advance the counters
  always_comb begin
    q_push    = 1'b0;
    q_wdata   = '0;
    col_nxt   = col_r;
    frow_nxt  = frow_r;
    rbp_nxt   = rbp_r;
    phase_nxt = phase_r;
    held_nxt  = held_r;

    q_wdata.column = col_r[11:0];
    q_wdata.row    = row_out[11:0];
    q_wdata.last0  = (col_p1 == geom.w) && last_row;
    q_wdata.last1  = (col_p2 == geom.w) && last_row;

    if (accept && in_data.kind == KIND_PALETTE) begin
      q_push        = 1'b1;
      q_wdata.op    = OP_PAL_WR;
      q_wdata.idx0  = in_data.palette_index;
      q_wdata.rgb   = {in_data.palette_red, in_data.palette_green, in_data.palette_blue};
    end else if (accept) begin
      if (in_row) begin
        unique case (geom.fmt)
          FMT_PAL4: begin
            q_push         = 1'b1;
            q_wdata.op     = OP_LOOKUP;
            q_wdata.idx0   = {4'd0, b[7:4]};
            q_wdata.idx1   = {4'd0, b[3:0]};
            // drop the low nibble past the end of an odd-width row
            q_wdata.two_px = col_p1 < geom.w;
            col_nxt        = q_wdata.two_px ? col_p2 : col_p1;
          end
          FMT_PAL8: begin
            q_push       = 1'b1;
            q_wdata.op   = OP_LOOKUP;
            q_wdata.idx0 = b;
            col_nxt      = col_p1;
          end
          default: begin
            // blue, green, red arrive in that order
            if (phase_r == PH_BLUE) begin
              held_nxt  = {8'd0, b};
              phase_nxt = PH_GREEN;
            end else if (phase_r == PH_GREEN) begin
              held_nxt  = {b, held_r[7:0]};
              phase_nxt = PH_RED;
            end else begin
              q_push      = 1'b1;
              q_wdata.op  = OP_DIRECT;
              q_wdata.rgb = {b, held_r};
              col_nxt     = col_p1;
              held_nxt    = '0;
              phase_nxt   = PH_BLUE;
            end
          end
        endcase
      end

      // Skip padding and close the row at the stride
      rbp_nxt = rbp_inc;
      if (rbp_inc >= geom.stride) begin
        rbp_nxt   = '0;
        col_nxt   = '0;
        phase_nxt = PH_BLUE;
        held_nxt  = '0;
        frow_nxt  = (frow_p1 >= geom.h) ? '0 : frow_p1;
      end
    end
  end

  // Counter registers
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r   <= '0;
      frow_r  <= '0;
      rbp_r   <= '0;
      phase_r <= PH_BLUE;
      held_r  <= '0;
    end else begin
      col_r   <= col_nxt;
      frow_r  <= frow_nxt;
      rbp_r   <= rbp_nxt;
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ===== rtl/bpd_queue.sv =====
// Short FIFO of decoded work between the front and back ends.
// Depends on bpd_pkg.
`timescale 1ns / 1ps

module bpd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bpd_pkg::work_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output bpd_pkg::work_t head
);
  import bpd_pkg::*;

  work_t          slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r, count_nxt;

  assign full      = count_r == (Q_AW+1)'(Q_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = slot_r[rd_ptr_r];

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (Q_AW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (Q_AW+1)'(1);
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/bpd_back.sv =====
// Back end: palette writes and lookups, pixel sequencing, output register.
// Depends on bpd_pkg and bpd_ram; drains bpd_queue.
`timescale 1ns / 1ps

module bpd_back #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  bpd_pkg::work_t     q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output bpd_pkg::out_item_t out_data
);
  import bpd_pkg::*;

  localparam int         AW      = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] DEPTH_C = 9'(PALETTE_DEPTH);

  logic      b_valid_r, b_valid_nxt;
  work_t     b_work_r, b_work_nxt;
  logic      b_sel_r, b_sel_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic        out_load, b_last_px, b_done, b_free;
  logic        head_wr, ram_we, ram_re;
  logic [23:0] rd0, rd1, px_rgb;
  logic [7:0]  px_idx;
  logic        px_in_range;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Flow control through the lookup stage
  assign out_load  = !out_valid_r || !out_stall;
  assign b_last_px = !b_work_r.two_px || b_sel_r;
  assign b_done    = b_valid_r && out_load && b_last_px;
  assign b_free    = !b_valid_r || b_done;
  assign head_wr   = q_head.op == OP_PAL_WR;
  assign q_pop     = q_not_empty && (head_wr || b_free);
  assign ram_we    = q_pop && head_wr && ({1'b0, q_head.idx0} < DEPTH_C);
  assign ram_re    = q_pop && !head_wr;

  bpd_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_head.idx0[AW-1:0]),
    .wdata (q_head.rgb),
    .re    (ram_re),
    .raddr0(q_head.idx0[AW-1:0]),
    .raddr1(q_head.idx1[AW-1:0]),
    .rdata0(rd0),
    .rdata1(rd1)
  );

  // Advance the lookup stage
  always_comb begin
    b_valid_nxt = b_valid_r;
    b_work_nxt  = b_work_r;
    b_sel_nxt   = b_sel_r;
    if (ram_re) begin
      b_valid_nxt = 1'b1;
      b_work_nxt  = q_head;
      b_sel_nxt   = 1'b0;
    end else if (b_done) begin
      b_valid_nxt = 1'b0;
    end else if (b_valid_r && out_load) begin
      b_sel_nxt = 1'b1;
    end
  end

  // Build the current pixel; out-of-range palette reads give black
  always_comb begin
    px_idx      = b_sel_r ? b_work_r.idx1 : b_work_r.idx0;
    px_in_range = {1'b0, px_idx} < DEPTH_C;
    if (b_work_r.op == OP_LOOKUP) begin
      px_rgb = px_in_range ? (b_sel_r ? rd1 : rd0) : 24'd0;
    end else begin
      px_rgb = b_work_r.rgb;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt              = b_valid_r;
      out_data_nxt.red           = px_rgb[23:16];
      out_data_nxt.green         = px_rgb[15:8];
      out_data_nxt.blue          = px_rgb[7:0];
      out_data_nxt.column        = b_work_r.column + {11'd0, b_sel_r};
      out_data_nxt.row           = b_work_r.row;
      out_data_nxt.last_of_image = b_sel_r ? b_work_r.last1 : b_work_r.last0;
      out_data_nxt.last_of_item  = b_last_px;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      b_sel_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      b_sel_r     <= b_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    b_work_r   <= b_work_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/bpd_checker.sv =====
// Port-level checks for the BMP pixel array decoder, bound to the top level.
// Depends on bpd_pkg and bmp_pixel_array_decoder_macros.svh.
`timescale 1ns / 1ps
`include "bmp_pixel_array_decoder_macros.svh"

module bpd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input bpd_pkg::out_item_t out_data
);
  import bpd_pkg::*;

  // Hold a stalled result
  `BPD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // The final pixel of an image always ends its request
  `BPD_ASSERT_IMP(a_last_image_ends_item, out_valid && out_data.last_of_image, out_data.last_of_item)

  // The final pixel of an image sits on the top row after the flip
  `BPD_ASSERT_IMP(a_last_image_top_row, out_valid && out_data.last_of_image, out_data.row == 12'd0)

  // The second pixel of a pair follows at once, one column on, same row
  `BPD_ASSERT_NXT(a_pair_follows, out_valid && !out_stall && !out_data.last_of_item, out_valid && out_data.column == 12'($past(out_data.column) + 12'd1) && out_data.row == $past(out_data.row))

endmodule

bind bmp_pixel_array_decoder bpd_checker u_bpd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ===== tb/sv/bmp_pixel_array_decoder_tb.sv =====
// Self-checking testbench for bmp_pixel_array_decoder: directed table, then random images.
// Depends on bpd_pkg and the decoder RTL; expected pixels come from an in-bench predictor.
`timescale 1ns / 1ps

module bmp_pixel_array_decoder_tb;
  import bpd_pkg::*;

  localparam int LIM_W        = 4096;
  localparam int LIM_H        = 4096;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  // Format code with no format of its own; decodes as 24-bit BGR
  localparam logic [1:0] FMT_UNUSED = 2'd3;

  typedef enum {ST_CFG, ST_PAL, ST_BYTE} step_kind_t;

  typedef struct {
    step_kind_t op;
    int         a;     // register index, palette index or data byte
    int         v;     // register value or palette colour
    bit         want_on;
    out_item_t  want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state
  logic [23:0] pal_shadow [256];
  logic [1:0]  fmt_reg;
  int          wid_reg;
  int          hgt_reg;
  int          col_cnt;
  int          frow_cnt;
  int          rpos;
  logic [1:0]  phase;
  logic [15:0] held;
  out_item_t   fresh [2];
  int          fresh_n;

  out_item_t   pending_pixels [$];
  step_t       plan [$];
  int          pixel_errors = 0;
  int          requests_sent = 0;
  int          tx_idle_pct = 7;
  int          rx_idle_pct = 60;

  bmp_pixel_array_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Stall the result side at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  function automatic int clamp_dim(int v, int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int row_data_bytes(logic [1:0] f, int w);
    unique case (f)
      FMT_PAL4: return (w + 1) / 2;
      FMT_PAL8: return w;
      default:  return w * 3;
    endcase
  endfunction

  function automatic in_item_t rand_request(logic k);
    in_item_t rq;
    rq.kind          = k;
    rq.palette_index = 8'($urandom_range(255));
    rq.palette_red   = 8'($urandom_range(255));
    rq.palette_green = 8'($urandom_range(255));
    rq.palette_blue  = 8'($urandom_range(255));
    rq.data_byte     = 8'($urandom_range(255));
    return rq;
  endfunction

  task automatic restart_image();
    col_cnt  = 0;
    frow_cnt = 0;
    rpos     = 0;
    phase    = PH_BLUE;
    held     = '0;
  endtask

  // Append one pixel at the current column and flipped row
  task automatic add_pixel(logic [23:0] rgb, int w, int h);
    out_item_t p;
    int        r;
    r                = h - 1 - frow_cnt;
    p.red            = rgb[23:16];
    p.green          = rgb[15:8];
    p.blue           = rgb[7:0];
    p.column         = col_cnt[11:0];
    p.row            = r[11:0];
    p.last_of_image  = (col_cnt + 1 == w) && (frow_cnt + 1 == h);
    p.last_of_item   = 1'b0;
    fresh[fresh_n]   = p;
    fresh_n++;
    col_cnt++;
  endtask

  // Work out the pixels one request gives and advance the shadow state
  task automatic decode_request(in_item_t rq);
    int         w;
    int         h;
    int         nbytes;
    int         stride;
    logic [7:0] b;
    fresh_n = 0;
    if (rq.kind == KIND_PALETTE) begin
      pal_shadow[rq.palette_index] = {rq.palette_red, rq.palette_green, rq.palette_blue};
      return;
    end
    w      = clamp_dim(wid_reg, LIM_W);
    h      = clamp_dim(hgt_reg, LIM_H);
    b      = rq.data_byte;
    nbytes = row_data_bytes(fmt_reg, w);
    stride = (nbytes + 3) & ~3;
    if (rpos < nbytes) begin
      if (fmt_reg == FMT_PAL4) begin
        add_pixel(pal_shadow[{4'h0, b[7:4]}], w, h);
        // drop the trailing nibble of an odd-width row
        if (col_cnt < w) add_pixel(pal_shadow[{4'h0, b[3:0]}], w, h);
      end else if (fmt_reg == FMT_PAL8) begin
        add_pixel(pal_shadow[b], w, h);
      end else if (phase == PH_BLUE) begin
        held  = {8'h00, b};
        phase = PH_GREEN;
      end else if (phase == PH_GREEN) begin
        held[15:8] = b;
        phase      = PH_RED;
      end else begin
        add_pixel({b, held}, w, h);
        phase = PH_BLUE;
        held  = '0;
      end
    end
    // Skip row padding and wrap at the end of the image
    rpos++;
    if (rpos >= stride) begin
      rpos     = 0;
      col_cnt  = 0;
      phase    = PH_BLUE;
      held     = '0;
      frow_cnt++;
      if (frow_cnt >= h) frow_cnt = 0;
    end
    if (fresh_n > 0) fresh[fresh_n - 1].last_of_item = 1'b1;
  endtask

  // Offer one request, hold it until accepted, then record its pixels (or the given expectation)
  task automatic send_request(in_item_t rq, bit want_on = 1'b0, out_item_t want = '0);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data  = rq;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    decode_request(rq);
    if (want_on) pending_pixels.push_back(want);
    else for (int i = 0; i < fresh_n; i++) pending_pixels.push_back(fresh[i]);
  endtask

  // Write one register once the decoder has gone idle
  task automatic write_reg(logic [1:0] idx, int val);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    unique case (idx)
      REG_FORMAT: fmt_reg = pwdata[1:0];
      REG_WIDTH:  wid_reg = int'(pwdata[12:0]);
      REG_HEIGHT: hgt_reg = int'(pwdata[12:0]);
      default: ;
    endcase
    restart_image();
  endtask

  task automatic add_step(step_kind_t op, int a, int v, bit want_on = 1'b0,
                          out_item_t want = '0);
    step_t s;
    s.op      = op;
    s.a       = a;
    s.v       = v;
    s.want_on = want_on;
    s.want    = want;
    plan.push_back(s);
  endtask

  task automatic note_error(string msg);
    pixel_errors++;
    if (pixel_errors <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // Compare each accepted pixel with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        note_error($sformatf("unexpected pixel rgb %06h col %0d row %0d",
                   {out_data.red, out_data.green, out_data.blue},
                   out_data.column, out_data.row));
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.red !== want.red || out_data.green !== want.green ||
            out_data.blue !== want.blue || out_data.column !== want.column ||
            out_data.row !== want.row || out_data.last_of_image !== want.last_of_image ||
            out_data.last_of_item !== want.last_of_item) begin
          note_error($sformatf(
            "pixel mismatch exp rgb %06h col %0d row %0d li %0b lt %0b, got rgb %06h col %0d row %0d li %0b lt %0b",
            {want.red, want.green, want.blue}, want.column, want.row,
            want.last_of_image, want.last_of_item,
            {out_data.red, out_data.green, out_data.blue}, out_data.column,
            out_data.row, out_data.last_of_image, out_data.last_of_item));
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #4_000_000;
    $display("bmp_pixel_array_decoder regression: fail");
    $finish;
  end

  initial begin
    in_item_t rq;
    int       base;
    int       prog;
    int       r;
    int       w;
    int       h;
    int       stride;
    int       total;
    logic [1:0] f;

    fmt_reg = FMT_BGR24;
    wid_reg = 1;
    hgt_reg = 1;
    restart_image();

    // Directed table: reset geometry, odd 4-bit width, 8-bit, unused format
    add_step(ST_BYTE, 8'h11, 0);
    add_step(ST_BYTE, 8'h22, 0);
    add_step(ST_BYTE, 8'h33, 0, 1'b1, {8'h33, 8'h22, 8'h11, 12'd0, 12'd0, 1'b1, 1'b1});
    add_step(ST_BYTE, 8'h00, 0);
    add_step(ST_PAL, 0, 24'hFF0080);
    add_step(ST_PAL, 15, 24'h123456);
    add_step(ST_PAL, 255, 24'h00FF01);
    add_step(ST_CFG, REG_FORMAT, FMT_PAL4);
    add_step(ST_CFG, REG_WIDTH, 3);
    add_step(ST_CFG, REG_HEIGHT, 2);
    add_step(ST_BYTE, 8'hF0, 0);
    add_step(ST_BYTE, 8'h0F, 0, 1'b1, {8'hFF, 8'h00, 8'h80, 12'd2, 12'd1, 1'b0, 1'b1});
    add_step(ST_BYTE, 8'hAA, 0);
    add_step(ST_BYTE, 8'h55, 0);
    add_step(ST_BYTE, 8'hFF, 0);
    add_step(ST_BYTE, 8'h00, 0, 1'b1, {8'hFF, 8'h00, 8'h80, 12'd2, 12'd0, 1'b1, 1'b1});
    add_step(ST_BYTE, 8'hFF, 0);
    add_step(ST_BYTE, 8'h00, 0);
    add_step(ST_CFG, REG_FORMAT, FMT_PAL8);
    add_step(ST_CFG, REG_WIDTH, 1);
    add_step(ST_CFG, REG_HEIGHT, 1);
    add_step(ST_BYTE, 8'hFF, 0, 1'b1, {8'h00, 8'hFF, 8'h01, 12'd0, 12'd0, 1'b1, 1'b1});
    add_step(ST_BYTE, 8'hFF, 0);
    add_step(ST_BYTE, 8'h00, 0);
    add_step(ST_BYTE, 8'h7F, 0);
    add_step(ST_BYTE, 8'h00, 0, 1'b1, {8'hFF, 8'h00, 8'h80, 12'd0, 12'd0, 1'b1, 1'b1});
    add_step(ST_CFG, REG_FORMAT, FMT_UNUSED);
    add_step(ST_CFG, REG_WIDTH, 0);
    add_step(ST_CFG, REG_HEIGHT, 0);
    add_step(ST_BYTE, 8'hFF, 0);
    add_step(ST_BYTE, 8'hFF, 0);
    add_step(ST_BYTE, 8'hFF, 0, 1'b1, {8'hFF, 8'hFF, 8'hFF, 12'd0, 12'd0, 1'b1, 1'b1});
    add_step(ST_BYTE, 8'h00, 0);

    // Hold reset, then release on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      unique case (plan[i].op)
        ST_CFG: write_reg(plan[i].a[1:0], plan[i].v);
        ST_PAL: begin
          rq               = '0;
          rq.kind          = KIND_PALETTE;
          rq.palette_index = plan[i].a[7:0];
          {rq.palette_red, rq.palette_green, rq.palette_blue} = plan[i].v[23:0];
          send_request(rq);
        end
        default: begin
          rq           = '0;
          rq.kind      = KIND_PIXEL;
          rq.data_byte = plan[i].a[7:0];
          send_request(rq, plan[i].want_on, plan[i].want);
        end
      endcase
    end

    // Fill the whole palette before any random index is read
    for (int i = 0; i < 256; i++) begin
      rq               = rand_request(KIND_PALETTE);
      rq.palette_index = 8'(i);
      send_request(rq);
    end

    // Random images: mostly whole images, some cut short, palette updates mixed in
    base = requests_sent;
    while (requests_sent - base < 320) begin
      prog = requests_sent - base;
      if (prog < 107) begin
        tx_idle_pct = 7;
        rx_idle_pct = 60;
      end else if (prog < 214) begin
        tx_idle_pct = 60;
        rx_idle_pct = 7;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      f = 2'($urandom_range(3));
      r = $urandom_range(99);
      if (r < 5) w = 0;
      else if (r < 8) w = 4096;
      else if (r < 11) w = $urandom_range(4097, 8191);
      else w = $urandom_range(1, 12);
      r = $urandom_range(99);
      if (r < 5) h = 0;
      else if (r < 8) h = $urandom_range(4096, 8191);
      else h = $urandom_range(1, 3);
      write_reg(REG_FORMAT, f);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      stride = (row_data_bytes(f, clamp_dim(w, LIM_W)) + 3) & ~3;
      total  = stride * clamp_dim(h, LIM_H) * $urandom_range(1, 2);
      if (total > 96 || $urandom_range(99) < 15)
        total = $urandom_range(1, (total < 96) ? total : 96);
      for (int i = 0; i < total; i++) begin
        if ($urandom_range(99) < 4) send_request(rand_request(KIND_PALETTE));
        send_request(rand_request(KIND_PIXEL));
      end
    end

    // Drain and report
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pixel_errors == 0) begin
      $display("bmp_pixel_array_decoder regression: pass");
    end else begin
      $display("bmp_pixel_array_decoder regression: fail");
    end
    $finish;
  end

endmodule
